### design/peab_pkg.sv
`default_nettype none
package peab_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int POS_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int CNT_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int RING_AW   = $clog2(2 * MAX_WIDTH + 2);

	localparam int STEP_W    = 4;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(8);

	localparam int N_W    = 4;
	localparam int SUM_W  = 13;
	localparam int NUM_W  = 17;
	localparam int M_W    = NUM_W - 4;
	localparam int RCP_W  = 14;
	localparam int RCP_SH = 16;
	localparam int PROD_W = M_W + RCP_W;
	localparam int Q_W    = PROD_W - RCP_SH;
	localparam int DV_W   = 6;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_ALPHA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHADOW_ALPHA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHADOW_INDEX = 3'd4;

	typedef enum logic [1:0] {
		FUNC_PAL   = 2'd0,
		FUNC_PIX   = 2'd1,
		FUNC_FLUSH = 2'd2
	} func_t;

	typedef struct packed {
		logic              pal_wr;
		logic              pix_wr;
		logic              start;
		logic              rd_line;
		logic              rd_pal;
		logic              acc;
		logic              num;
		logic              div;
		logic              fix;
		logic              load_out;
		logic [STEP_W-1:0] step;
	} peab_cmd_t;

	typedef struct packed {
		logic frame_full;
		logic pix_emit;
		logic pend;
		logic center_zero;
	} peab_stat_t;

	// neighbor walk: step 0 is the center, then raster order around it
	function automatic logic signed [1:0] nb_dx(input logic [STEP_W-1:0] k);
		logic signed [1:0] r;
		case (k) inside
			4'd1, 4'd4, 4'd6: r = -2'sd1;
			4'd3, 4'd5, 4'd8: r = 2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] nb_dy(input logic [STEP_W-1:0] k);
		logic signed [1:0] r;
		case (k) inside
			4'd1, 4'd2, 4'd3: r = -2'sd1;
			4'd6, 4'd7, 4'd8: r = 2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

	// ceil(2^16 / (5*n))
	function automatic logic [RCP_W-1:0] recip(input logic [N_W-1:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			4'd1:    r = 14'd13108;
			4'd2:    r = 14'd6554;
			4'd3:    r = 14'd4370;
			4'd4:    r = 14'd3277;
			4'd5:    r = 14'd2622;
			4'd6:    r = 14'd2185;
			4'd7:    r = 14'd1873;
			4'd8:    r = 14'd1639;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### design/peab_ctl.sv
`default_nettype none
module peab_ctl
	import peab_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic [1:0] s_tuser,
	output logic            s_tready,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	input  wire peab_stat_t stat,
	output peab_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_LINE, S_PAL, S_ACC, S_NUM, S_DIV, S_FIX, S_PUSH
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] k_q;
	logic              out_valid_q;
	logic              go;
	func_t             func;

	always_comb begin
		func = func_t'(s_tuser);
		cmd = '0;
		cmd.step = k_q;
		go = 1'b0;
		if (s_tvalid && state_q == S_IDLE) begin
			unique case (func)
				FUNC_PAL: cmd.pal_wr = 1'b1;
				FUNC_PIX: begin
					if (!stat.frame_full) begin
						cmd.pix_wr = 1'b1;
						go = stat.pix_emit;
					end else begin
						go = stat.pend;
					end
				end
				FUNC_FLUSH: go = stat.frame_full && stat.pend;
				default: ;
			endcase
		end
		cmd.start    = go;
		cmd.rd_line  = (state_q == S_LINE);
		cmd.rd_pal   = (state_q == S_PAL);
		cmd.acc      = (state_q == S_ACC);
		cmd.num      = (state_q == S_NUM);
		cmd.div      = (state_q == S_DIV);
		cmd.fix      = (state_q == S_FIX);
		cmd.load_out = (state_q == S_PUSH) && (!out_valid_q || m_tready);
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						k_q     <= '0;
						state_q <= S_LINE;
					end
				end
				S_LINE: state_q <= S_PAL;
				S_PAL:  state_q <= S_ACC;
				S_ACC: begin
					if (k_q == '0 && !stat.center_zero) begin
						state_q <= S_FIX;
					end else if (k_q == STEP_LAST) begin
						state_q <= S_NUM;
					end else begin
						k_q     <= k_q + STEP_W'(1);
						state_q <= S_LINE;
					end
				end
				S_NUM: state_q <= S_DIV;
				S_DIV: state_q <= S_FIX;
				S_FIX: state_q <= S_PUSH;
				S_PUSH: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= STEP_LAST) else $error("neighbor step out of range");

	a_pix_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_wr |-> !stat.frame_full) else $error("pixel stored past frame end");

	a_start_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> stat.pend) else $error("result started with none pending");

endmodule
`default_nettype wire

### design/peab_dp.sv
`default_nettype none
module peab_dp
	import peab_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic [31:0]          in_data,
	input  wire peab_cmd_t            cmd,
	output peab_stat_t                stat,
	output logic [31:0]               out_data,
	output logic                      out_last
);

	localparam int AREA_W = 2 * CFG_W;

	logic [CFG_W-1:0] w_q, h_q;
	logic [7:0]       na_q, sa_q, si_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] recv_q, e_q;
	logic [POS_W-1:0] ex_q;
	logic [ROW_W-1:0] ey_q;

	logic [7:0]  line_ram_q [2**RING_AW];
	logic [23:0] pal_ram_q  [256];
	logic [7:0]  line_q;
	logic [23:0] pal_q;

	logic [7:0]       d_q;
	logic [23:0]      col_q;
	logic [N_W-1:0]   n_q;
	logic [SUM_W-1:0] sum_q [3];
	logic [M_W-1:0]   m_q   [3];
	logic [Q_W-1:0]   q0_q  [3];
	logic [RCP_W-1:0] rcp_q;
	logic [DV_W-1:0]  dv_q;
	logic [7:0]       res_q [3];

	logic [AREA_W-1:0]  area;
	logic [CFG_W-1:0]   clamp_w, clamp_h;
	logic signed [1:0]  dx, dy;
	logic [RING_AW-1:0] wofs, row_term, col_term, rd_addr;
	logic               nb_ok, corner, use_pal;
	logic [7:0]         alpha;
	logic [CNT_W-1:0]   e_next;

	assign area = AREA_W'(w_q) * AREA_W'(h_q);

	always_comb begin
		clamp_w = cfg_data;
		if (cfg_data == '0) clamp_w = CFG_W'(1);
		else if (cfg_data > CFG_W'(MAX_WIDTH)) clamp_w = CFG_W'(MAX_WIDTH);
		clamp_h = cfg_data;
		if (cfg_data == '0) clamp_h = CFG_W'(1);
		else if (cfg_data > CFG_W'(MAX_HEIGHT)) clamp_h = CFG_W'(MAX_HEIGHT);
	end

	always_comb begin
		dx       = nb_dx(cmd.step);
		dy       = nb_dy(cmd.step);
		wofs     = RING_AW'(w_q);
		row_term = '0;
		if (dy == 2'sd1) row_term = wofs;
		else if (dy == -2'sd1) row_term = -wofs;
		col_term = {{(RING_AW-2){dx[1]}}, dx};
		rd_addr  = e_q[RING_AW-1:0] + row_term + col_term;
		nb_ok = 1'b1;
		if (dy == -2'sd1 && ey_q == '0) nb_ok = 1'b0;
		if (dy == 2'sd1 && (CFG_W'(ey_q) + CFG_W'(1)) >= h_q) nb_ok = 1'b0;
		if (dx == -2'sd1 && ex_q == '0) nb_ok = 1'b0;
		if (dx == 2'sd1 && (CFG_W'(ex_q) + CFG_W'(1)) >= w_q) nb_ok = 1'b0;
		corner  = (dx != 2'sd0) && (dy != 2'sd0);
		use_pal = (d_q != 8'd0) || (n_q == '0);
		if (d_q == si_q) alpha = sa_q;
		else if (d_q == 8'd0) alpha = 8'd0;
		else alpha = na_q;
		e_next = e_q + CNT_W'(1);
	end

	assign stat.frame_full  = (recv_q >= total_q);
	assign stat.pix_emit    = (recv_q >= (CNT_W'(w_q) + CNT_W'(1)));
	assign stat.pend        = (e_q < total_q);
	assign stat.center_zero = (line_q == 8'd0);

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= CFG_W'(1);
			h_q     <= CFG_W'(1);
			na_q    <= 8'd255;
			sa_q    <= 8'd0;
			si_q    <= 8'd0;
			total_q <= CNT_W'(1);
			recv_q  <= '0;
			e_q     <= '0;
			ex_q    <= '0;
			ey_q    <= '0;
		end else begin
			total_q <= area[CNT_W-1:0];
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH: begin
						w_q    <= clamp_w;
						recv_q <= '0;
						e_q    <= '0;
						ex_q   <= '0;
						ey_q   <= '0;
					end
					REG_HEIGHT: begin
						h_q    <= clamp_h;
						recv_q <= '0;
						e_q    <= '0;
						ex_q   <= '0;
						ey_q   <= '0;
					end
					REG_NORMAL_ALPHA: na_q <= cfg_data[7:0];
					REG_SHADOW_ALPHA: sa_q <= cfg_data[7:0];
					REG_SHADOW_INDEX: si_q <= cfg_data[7:0];
					default: ;
				endcase
			end else if (cmd.pix_wr) begin
				recv_q <= recv_q + CNT_W'(1);
			end else if (cmd.load_out) begin
				if (e_next >= total_q) begin
					recv_q <= '0;
					e_q    <= '0;
					ex_q   <= '0;
					ey_q   <= '0;
				end else begin
					e_q <= e_next;
					if ((CFG_W'(ex_q) + CFG_W'(1)) == w_q) begin
						ex_q <= '0;
						ey_q <= ey_q + ROW_W'(1);
					end else begin
						ex_q <= ex_q + POS_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_wr) line_ram_q[recv_q[RING_AW-1:0]] <= in_data[7:0];
		if (cmd.rd_line) line_q <= line_ram_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.pal_wr) pal_ram_q[in_data[7:0]] <= in_data[31:8];
		if (cmd.rd_pal) pal_q <= pal_ram_q[line_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q <= '0;
			for (int c = 0; c < 3; c++) sum_q[c] <= '0;
		end
		if (cmd.acc) begin
			if (cmd.step == '0) begin
				d_q   <= line_q;
				col_q <= pal_q;
			end else if (nb_ok && line_q != 8'd0) begin
				n_q <= n_q + N_W'(1);
				for (int c = 0; c < 3; c++) begin
					if (corner) sum_q[c] <= sum_q[c] + SUM_W'(pal_q[8*c +: 8]);
					else sum_q[c] <= sum_q[c] + (SUM_W'(pal_q[8*c +: 8]) << 2);
				end
			end
		end
		if (cmd.num) begin
			rcp_q <= recip(n_q);
			dv_q  <= DV_W'(n_q) * DV_W'(5);
			for (int c = 0; c < 3; c++) begin
				logic [NUM_W-1:0] numv;
				numv = NUM_W'(sum_q[c]) * NUM_W'(15)
					+ ((NUM_W'(n_q) * NUM_W'(col_q[8*c +: 8])) << 4);
				m_q[c] <= numv[NUM_W-1:4];
			end
		end
		if (cmd.div) begin
			for (int c = 0; c < 3; c++) begin
				logic [PROD_W-1:0] prod;
				prod = PROD_W'(m_q[c]) * PROD_W'(rcp_q);
				q0_q[c] <= prod[PROD_W-1:RCP_SH];
			end
		end
		if (cmd.fix) begin
			for (int c = 0; c < 3; c++) begin
				logic [Q_W+DV_W-1:0] back;
				logic [Q_W-1:0]      q;
				back = (Q_W+DV_W)'(q0_q[c]) * (Q_W+DV_W)'(dv_q);
				q = (back > (Q_W+DV_W)'(m_q[c])) ? q0_q[c] - Q_W'(1) : q0_q[c];
				if (use_pal) res_q[c] <= col_q[8*c +: 8];
				else if (q > Q_W'(255)) res_q[c] <= 8'd255;
				else res_q[c] <= q[7:0];
			end
		end
		if (cmd.load_out) begin
			out_data <= {alpha, res_q[2], res_q[1], res_q[0]};
			out_last <= (e_next == total_q);
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		CFG_W'(ex_q) < w_q) else $error("column past frame width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		CFG_W'(ey_q) < h_q) else $error("row past frame height");

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		e_q <= recv_q) else $error("result position ahead of input");

endmodule
`default_nettype wire

### design/palette_expand_alpha_bleed_unit.sv
`default_nettype none
// channel   dir  fields
// s_*       in   tdata: index[7:0] color[31:8]; tuser: func[1:0]
// m_*       out  tdata: red[7:0] green[15:8] blue[23:16] alpha[31:24]; tlast: last
// cfg_*     in   cfg_index selects register, cfg_data up to 11 bits
//
// A palette write, or a pixel without a result, is taken without leaving idle.
// A result for a non-zero index reads the center only; for index 0 it is
// set by the serial walk over the 3x3 neighborhood through the single read
// port of the line ring and then of the palette (read, read, add per neighbor).
// arst_n clears counters, config and control; line ring, palette, datapath are not cleared.
// A finished result waits in the output register and the next request is taken;
// a second result holds the input until that register is taken.
module palette_expand_alpha_bleed_unit
	import peab_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [31:0]          s_tdata,  // index, color
	input  wire logic [1:0]           s_tuser,  // func
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [31:0]               m_tdata,  // red, green, blue, alpha
	output logic                      m_tlast,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	peab_cmd_t  cmd;
	peab_stat_t stat;

	peab_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	peab_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

### sim/palette_expand_alpha_bleed_unit_chk.sv
`default_nettype none
module palette_expand_alpha_bleed_unit_chk
	import peab_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [31:0]          s_tdata,
	input  wire logic [1:0]           s_tuser,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [31:0]          m_tdata,
	input  wire logic                 m_tlast,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output int                        fails,
	output int                        pending,
	output int                        results,
	output int                        bleeds,
	output int                        frames
);

	localparam int RING = 2 * MAX_WIDTH + 4;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} rgba_t;

	rgba_t       rgba_q[$];
	logic [23:0] pal[256];
	logic [7:0]  ring[RING];
	int unsigned width, height, emitted, received;
	logic [7:0]  norm_a, shad_a, shad_idx;

	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
		int unsigned r;
		r = v;
		if (r < 1) r = 1;
		if (r > 1024) r = 1024;
		return r;
	endfunction

	task automatic restart();
		emitted = 0;
		received = 0;
	endtask

	task automatic expand_pixel();
		int unsigned x, y, e, d, total, n, pos, r, wt, v, ch;
		int unsigned acc[3];
		logic [23:0] col, c;
		rgba_t t;
		total = width * height;
		e = emitted;
		x = e % width;
		y = e / width;
		d = ring[e % RING];
		col = pal[d];
		if (d == shad_idx) t.alpha = shad_a;
		else if (d == 0) t.alpha = 8'd0;
		else t.alpha = norm_a;
		if (d == 0) begin
			acc = '{0, 0, 0};
			n = 0;
			for (int dy = -1; dy <= 1; dy++)
				for (int dx = -1; dx <= 1; dx++) begin
					if (dx == 0 && dy == 0) continue;
					if ((dy < 0 && y == 0) || (dy > 0 && y + 1 >= height)) continue;
					if ((dx < 0 && x == 0) || (dx > 0 && x + 1 >= width)) continue;
					pos = (int'(y) + dy) * width + (int'(x) + dx);
					r = ring[pos % RING];
					if (r == 0) continue;
					wt = (dx != 0 && dy != 0) ? 1 : 4;
					c = pal[r];
					for (ch = 0; ch < 3; ch++) acc[ch] += wt * c[8*ch +: 8];
					n++;
				end
			if (n != 0) begin
				bleeds++;
				for (ch = 0; ch < 3; ch++) begin
					v = (15 * acc[ch] + 16 * n * col[8*ch +: 8]) / (80 * n);
					if (v > 255) v = 255;
					col[8*ch +: 8] = v[7:0];
				end
			end
		end
		t.red = col[7:0];
		t.green = col[15:8];
		t.blue = col[23:16];
		t.last = (e + 1 == total);
		rgba_q.push_back(t);
		emitted = e + 1;
		if (emitted >= total) begin
			frames++;
			restart();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rgba_t t, got;
		if (!arst_n) begin
			rgba_q.delete();
			width = 1;
			height = 1;
			norm_a = 8'd255;
			shad_a = 8'd0;
			shad_idx = 8'd0;
			restart();
			fails = 0;
			pending = 0;
			results = 0;
			bleeds = 0;
			frames = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24], m_tlast};
				results++;
				if (rgba_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result %h", $time, got);
				end else begin
					t = rgba_q.pop_front();
					if (got.red !== t.red)
						$display("%0t: red exp %h got %h", $time, t.red, got.red);
					if (got.green !== t.green)
						$display("%0t: green exp %h got %h", $time, t.green, got.green);
					if (got.blue !== t.blue)
						$display("%0t: blue exp %h got %h", $time, t.blue, got.blue);
					if (got.alpha !== t.alpha)
						$display("%0t: alpha exp %h got %h", $time, t.alpha, got.alpha);
					if (got.last !== t.last)
						$display("%0t: last exp %b got %b", $time, t.last, got.last);
					if (got !== t) fails++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH: begin
						width = clamp_dim(cfg_data);
						restart();
					end
					REG_HEIGHT: begin
						height = clamp_dim(cfg_data);
						restart();
					end
					REG_NORMAL_ALPHA: norm_a = cfg_data[7:0];
					REG_SHADOW_ALPHA: shad_a = cfg_data[7:0];
					REG_SHADOW_INDEX: shad_idx = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == FUNC_PAL) begin
					pal[s_tdata[7:0]] = s_tdata[31:8];
				end else if (s_tuser == FUNC_PIX && received < width * height) begin
					ring[received % RING] = s_tdata[7:0];
					received++;
					if (received >= width + 2) expand_pixel();
				end else if (s_tuser == FUNC_PIX || s_tuser == FUNC_FLUSH) begin
					if (received >= width * height && emitted < width * height)
						expand_pixel();
				end
			end
			pending = rgba_q.size();
		end
	end

endmodule
`default_nettype wire

### sim/palette_expand_alpha_bleed_unit_tb.sv
`default_nettype none
module palette_expand_alpha_bleed_unit_tb;
	import peab_pkg::*;

	localparam logic [1:0] FUNC_IDLE = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata = '0;   // index[7:0], color[31:8]
	logic [1:0]           s_tuser = '0;   // func[1:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;        // red, green, blue, alpha
	logic                 m_tlast;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int fails, pending, results, bleeds, frames;
	int pix_sent = 0;
	int stall_mode = 0;
	int gap_mode = 1;
	bit hold_req = 0;
	int cur_w = 1, shadow = 0;

	always #6 clk = ~clk;

	palette_expand_alpha_bleed_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	palette_expand_alpha_bleed_unit_chk chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending), .results(results), .bleeds(bleeds),
		.frames(frames)
	);

	function automatic int pick_gap(input int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == 0 || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// output side
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end else begin
				case (stall_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: begin
						if ($urandom_range(0, 49) == 0) begin
							m_tready <= 1'b0;
							repeat ($urandom_range(10, 40)) @(negedge clk);
						end else
							m_tready <= ($urandom_range(0, 9) < 3);
					end
				endcase
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send(input logic [1:0] f, input logic [7:0] idx, input logic [23:0] color);
		int g;
		s_tuser <= f;
		s_tdata <= {color, idx};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		if (f == FUNC_PIX) pix_sent++;
		g = pick_gap(gap_mode);
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cur_w = (w == 0) ? 1 : (w > 1024) ? 1024 : w;
	endtask

	function automatic logic [7:0] rand_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return 8'd0;
		if (r < 42) return shadow[7:0];
		return 8'($urandom_range(0, 255));
	endfunction

	// sends npix pixels with some palette writes and noise mixed in, then flushes if flush is set
	task automatic frame(input int npix, input bit flush);
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(0, 19) == 0)
				send(FUNC_PAL, 8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)));
			if ($urandom_range(0, 39) == 0)
				send(FUNC_IDLE, 8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)));
			send(FUNC_PIX, rand_index(), 24'($urandom_range(0, 24'hFFFFFF)));
		end
		if (flush)
			for (int i = 0; i < cur_w + 2 + $urandom_range(0, 2); i++)
				send(($urandom_range(0, 4) == 0) ? FUNC_PIX : FUNC_FLUSH,
					8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)));
	endtask

	initial begin
		int w, h;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// load the whole palette so no unwritten entry is ever read
		gap_mode = 0;
		for (int i = 0; i < 256; i++)
			send(FUNC_PAL, 8'(i), (i == 255) ? 24'hFFFFFF : (i == 1) ? 24'h000000 :
				24'($urandom_range(0, 24'hFFFFFF)));

		// directed: 3x3 frames around a zero center, shadow index, noise
		drain();
		set_geometry(11'd3, 11'd3);
		write_reg(REG_SHADOW_INDEX, 11'd200);
		write_reg(REG_SHADOW_ALPHA, 11'd128);
		write_reg(REG_NORMAL_ALPHA, 11'd255);
		shadow = 200;
		send(FUNC_PIX, 8'd255, '0); send(FUNC_PIX, 8'd255, '0); send(FUNC_PIX, 8'd1, '0);
		send(FUNC_PIX, 8'd255, '0); send(FUNC_PIX, 8'd0, '0);   send(FUNC_PIX, 8'd255, '0);
		send(FUNC_PIX, 8'd200, '0); send(FUNC_PIX, 8'd0, '0);   send(FUNC_PIX, 8'd0, '0);
		send(FUNC_PIX, 8'd77, '0);   // after a full frame: acts as flush
		send(FUNC_IDLE, 8'hFF, 24'hFFFFFF);
		for (int i = 0; i < 6; i++) send(FUNC_FLUSH, 8'd0, '0);
		send(FUNC_PIX, 8'd0, '0); send(FUNC_FLUSH, 8'd0, '0);  // flush too early
		drain();
		write_reg(REG_SHADOW_INDEX, 11'd0);
		write_reg(REG_SHADOW_ALPHA, 11'd255);
		write_reg(REG_NORMAL_ALPHA, 11'd0);
		shadow = 0;
		set_geometry(11'd0, 11'd0);
		send(FUNC_PIX, 8'd0, '0); send(FUNC_FLUSH, 8'd0, '0); send(FUNC_FLUSH, 8'd0, '0);

		// extremes of geometry, clamped
		drain();
		gap_mode = 1;
		set_geometry(11'd2047, 11'd0);
		frame(30, 1'b0);
		drain();
		set_geometry(11'd0, 11'd2047);
		frame(120, 1'b0);
		drain();
		set_geometry(11'd1024, 11'd2);
		frame(40, 1'b0);

		// receiver holds off while the sender keeps going
		drain();
		set_geometry(11'd4, 11'd4);
		stall_mode = 0;
		hold_req = 1;
		frame(16, 1'b1);
		frame(16, 1'b1);

		pix_sent = 0;
		while (pix_sent < 450) begin
			drain();
			stall_mode = $urandom_range(0, 2);
			gap_mode = $urandom_range(0, 2);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			set_geometry(CFG_W'(w), CFG_W'(h));
			write_reg(REG_NORMAL_ALPHA, CFG_W'($urandom_range(0, 255)));
			write_reg(REG_SHADOW_ALPHA, CFG_W'($urandom_range(0, 255)));
			shadow = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
			write_reg(REG_SHADOW_INDEX, CFG_W'(shadow));
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_SHADOW_INDEX + CFG_IDX_W'(1 + $urandom_range(0, 2)), 11'h7FF);
			for (int f = $urandom_range(1, 3); f > 0; f--)
				frame(w * h, 1'b1);
			if ($urandom_range(0, 4) == 0) frame($urandom_range(0, w * h), 1'b0);
		end

		drain();
		$display("covered %0d results, %0d frames, %0d bled transparent pixels",
			results, frames, bleeds);
		if (fails == 0)
			$display("palette_expand_alpha_bleed_unit test passed");
		else
			$display("palette_expand_alpha_bleed_unit test failed");
		$finish;
	end

	initial begin
		#(12 * 3000000);
		$display("palette_expand_alpha_bleed_unit test failed");
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
design/peab_pkg.sv
design/peab_ctl.sv
design/peab_dp.sv
design/palette_expand_alpha_bleed_unit.sv
sim/palette_expand_alpha_bleed_unit_chk.sv
sim/palette_expand_alpha_bleed_unit_tb.sv
